// ----- src/gatk_pkg.sv -----
// Shared types and constants for the tilt Kalman filter.
`default_nettype none
package gatk_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int DivSteps  = DataWidth + FracBits;
  localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic signed [DataWidth-1:0] CovInit = DataWidth'(3 <<< FracBits);

  localparam logic [1:0] RegDt    = 2'd0;
  localparam logic [1:0] RegMeas  = 2'd1;
  localparam logic [1:0] RegQAng  = 2'd2;
  localparam logic [1:0] RegQBias = 2'd3;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALU,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  function automatic data_t sat_wide(input logic signed [DataWidth+1:0] v);
    data_t r;
    if (v > $signed({{2{VMax[DataWidth-1]}}, VMax})) r = VMax;
    else if (v < $signed({{2{VMin[DataWidth-1]}}, VMin})) r = VMin;
    else r = v[DataWidth-1:0];
    return r;
  endfunction

  // magnitude/sign to saturated signed value
  function automatic data_t sat_mag(input logic [2*DataWidth-1:0] u, input logic neg);
    logic [2*DataWidth-1:0] lim;
    logic [2*DataWidth-1:0] m;
    data_t r;
    lim = neg ? (2*DataWidth)'({1'b1, {(DataWidth-1){1'b0}}})
              : (2*DataWidth)'({1'b0, {(DataWidth-1){1'b1}}});
    m = (u > lim) ? lim : u;
    r = neg ? data_t'(-m[DataWidth-1:0]) : data_t'(m[DataWidth-1:0]);
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- src/gyro_accel_tilt_kalman.sv -----
// Top level: two-state tilt Kalman filter on one shared multiply/add unit.
// Sequence: 29 ALU steps, with two divisions (start, 48 quotient bits, done)
//   after step 8, then the output register is loaded in ST_DONE.
// One item at a time: in_ready low while an item is worked.
// A result left in the output register holds the next item at its last step.
// Reset: synchronous; angle/bias 0, covariance diag 3.0, registers to defaults.
`default_nettype none
module gyro_accel_tilt_kalman (
  input  wire  logic                 clk,
  input  wire  logic                 rst,
  input  wire  logic                 cfg_valid,
  output       logic                 cfg_ready,
  input  wire  logic [1:0]           cfg_index,
  input  wire  logic [31:0]          cfg_data,
  input  wire  logic                 in_valid,
  output       logic                 in_ready,
  input  wire  logic signed [31:0]   rate_sample,
  input  wire  logic signed [31:0]   tilt_sample,
  output       logic                 out_valid,
  input  wire  logic                 out_ready,
  output       logic signed [31:0]   angle_estimate,
  output       logic signed [31:0]   bias_estimate
);
  localparam int W = gatk_pkg::DataWidth;
  localparam int F = gatk_pkg::FracBits;

  gatk_pkg::state_t state, state_next;

  logic [16:0] dt_reg;
  logic [30:0] meas_reg, qa_reg, qb_reg;
  gatk_pkg::data_t ang, bias, p00, p01, p10, p11;
  gatk_pkg::data_t rate, meas;
  // scratch
  gatk_pkg::data_t t0, inn, s, ap00, ap01, k0, k1, c0, n00, n01, n10, n11, tmp;
  logic [4:0] step;
  logic       div_sel;

  // ALU operand select
  gatk_pkg::alu_op_t op;
  gatk_pkg::data_t   a, b, alu_y;

  logic div_start, div_busy, div_done;
  logic out_load;
  gatk_pkg::data_t dquot;

  assign cfg_ready = (state == gatk_pkg::ST_IDLE);
  assign in_ready  = (state == gatk_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      dt_reg   <= 17'd3277;
      meas_reg <= 31'd65536;
      qa_reg   <= 31'd66;
      qb_reg   <= 31'd197;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gatk_pkg::RegDt:    dt_reg   <= cfg_data[16:0];
        gatk_pkg::RegMeas:  meas_reg <= cfg_data[30:0];
        gatk_pkg::RegQAng:  qa_reg   <= cfg_data[30:0];
        gatk_pkg::RegQBias: qb_reg   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  gatk_pkg::data_t dt;
  assign dt = gatk_pkg::data_t'({15'd0, dt_reg});

  // microprogram: step -> (op, a, b); result written by step number
  always_comb begin
    op = gatk_pkg::OP_MUL;
    a = '0;
    b = '0;
    case (step)
      5'd0:  begin op = gatk_pkg::OP_SUB; a = rate; b = bias; end
      5'd1:  begin a = dt; b = tmp; end
      5'd2:  begin op = gatk_pkg::OP_ADD; a = ang; b = tmp; end
      5'd3:  begin op = gatk_pkg::OP_SUB; a = meas; b = ang; end
      5'd4:  begin op = gatk_pkg::OP_ADD; a = p00; b = {1'b0, meas_reg}; end
      5'd5:  begin a = dt; b = p10; end
      5'd6:  begin op = gatk_pkg::OP_SUB; a = p00; b = tmp; end
      5'd7:  begin a = dt; b = p11; end
      5'd8:  begin op = gatk_pkg::OP_SUB; a = p01; b = tmp; end
      5'd9:  begin a = k0; b = inn; end
      5'd10: begin op = gatk_pkg::OP_ADD; a = ang; b = tmp; end
      5'd11: begin a = k1; b = inn; end
      5'd12: begin op = gatk_pkg::OP_ADD; a = bias; b = tmp; end
      5'd13: begin a = dt; b = p01; end
      5'd14: begin op = gatk_pkg::OP_SUB; a = p00; b = tmp; end
      5'd15: begin a = dt; b = ap01; end
      5'd16: begin op = gatk_pkg::OP_SUB; a = ap00; b = tmp; end
      5'd17: begin a = dt; b = p11; end
      5'd18: begin op = gatk_pkg::OP_SUB; a = p10; b = tmp; end
      5'd19: begin a = k0; b = c0; end
      5'd20: begin op = gatk_pkg::OP_SUB; a = n00; b = tmp; end
      5'd21: begin op = gatk_pkg::OP_ADD; a = n00; b = {1'b0, qa_reg}; end
      // old p01 feeds both gain terms, so p01 is rewritten only after both reads
      5'd22: begin a = k1; b = p01; end
      5'd23: begin op = gatk_pkg::OP_SUB; a = p11; b = tmp; end
      5'd24: begin a = k1; b = c0; end
      5'd25: begin op = gatk_pkg::OP_SUB; a = n10; b = tmp; end
      5'd26: begin a = k0; b = p01; end
      5'd27: begin op = gatk_pkg::OP_SUB; a = ap01; b = tmp; end
      5'd28: begin op = gatk_pkg::OP_ADD; a = n11; b = {1'b0, qb_reg}; end
      default: ;
    endcase
  end

  logic [W:0]     mag_a, mag_b;
  logic [2*W-1:0] mp;
  assign mag_a = a[W-1] ? -{a[W-1], a} : {1'b0, a};
  assign mag_b = b[W-1] ? -{b[W-1], b} : {1'b0, b};
  assign mp    = mag_a * mag_b;

  always_comb begin
    case (op)
      gatk_pkg::OP_ADD: alu_y = gatk_pkg::sat_wide((W+2)'(a) + (W+2)'(b));
      gatk_pkg::OP_SUB: alu_y = gatk_pkg::sat_wide((W+2)'(a) - (W+2)'(b));
      default:          alu_y = gatk_pkg::sat_mag(mp >> F, a[W-1] ^ b[W-1]);
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      gatk_pkg::ST_IDLE:      if (in_valid && in_ready) state_next = gatk_pkg::ST_ALU;
      gatk_pkg::ST_ALU: begin
        if (step == 5'd8) state_next = gatk_pkg::ST_DIV_START;
        else if (step == 5'd28) state_next = gatk_pkg::ST_DONE;
      end
      gatk_pkg::ST_DIV_START: state_next = gatk_pkg::ST_DIV_WAIT;
      gatk_pkg::ST_DIV_WAIT:
        if (div_done && div_sel) state_next = gatk_pkg::ST_ALU;
        else if (div_done) state_next = gatk_pkg::ST_DIV_START;
      gatk_pkg::ST_DONE:      if (!out_valid || out_ready) state_next = gatk_pkg::ST_IDLE;
      default:                state_next = gatk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state == gatk_pkg::ST_DIV_START);
    out_load  = (state == gatk_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gatk_pkg::ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      div_sel   <= 1'b0;
      ang  <= '0;
      bias <= '0;
      p00  <= gatk_pkg::CovInit;
      p01  <= '0;
      p10  <= '0;
      p11  <= gatk_pkg::CovInit;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == gatk_pkg::ST_IDLE && in_valid && in_ready) begin
        rate    <= rate_sample;
        meas    <= tilt_sample;
        step    <= '0;
        div_sel <= 1'b0;
      end
      if (state == gatk_pkg::ST_DIV_WAIT && div_done) begin
        if (div_sel) k1 <= dquot;
        else k0 <= dquot;
        div_sel <= 1'b1;
      end
      if (state == gatk_pkg::ST_ALU) begin
        step <= step + 5'd1;
        case (step)
          5'd2, 5'd10: ang <= alu_y;
          5'd3:  inn  <= alu_y;
          5'd4:  s    <= alu_y;
          5'd6:  ap00 <= alu_y;
          5'd8:  ap01 <= alu_y;
          5'd12: bias <= alu_y;
          5'd14: c0   <= alu_y;
          5'd16: n00  <= alu_y;
          5'd18: n10  <= alu_y;
          5'd20: n00  <= alu_y;
          5'd21: p00  <= alu_y;
          5'd23: n11  <= alu_y;
          5'd25: p10  <= alu_y;
          5'd27: p01  <= alu_y;
          5'd28: p11  <= alu_y;
          default: tmp <= alu_y;
        endcase
      end
      if (out_load) begin
        angle_estimate <= ang;
        bias_estimate  <= bias;
      end
    end
  end

  // ap10 = p10 (old), read before p10 is rewritten at step 25
  assign t0 = div_sel ? p10 : ap00;
  assign n01 = '0;

  gatk_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (t0),
    .den  (s),
    .busy (div_busy),
    .done (div_done),
    .quot (dquot)
  );

  a_no_in_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != gatk_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_div_only_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == gatk_pkg::ST_DIV_WAIT)) else $error("stray div done");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == gatk_pkg::ST_DONE) else $error("bad out");
  a_div_not_busy_at_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy && n01 == '0) else $error("div overlap");
endmodule
`default_nettype wire

// ----- src/gatk_div.sv -----
// Restoring divider, one quotient bit per cycle, Q-format saturating.
`default_nettype none
module gatk_div (
  input  wire  logic                      clk,
  input  wire  logic                      rst,
  input  wire  logic                      start,
  input  wire  gatk_pkg::data_t           num,
  input  wire  gatk_pkg::data_t           den,
  output       logic                      busy,
  output       logic                      done,
  output       gatk_pkg::data_t           quot
);
  localparam int W = gatk_pkg::DataWidth;
  localparam int N = gatk_pkg::DivSteps;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  dividend;
  logic [W:0]    rem;
  logic [W:0]    dmag;
  logic [N-1:0]  q;
  logic          neg;
  logic          zero;
  logic [CW-1:0] cnt;
  logic [W:0]    nmag;
  logic [W+1:0]  trial;

  assign nmag  = num[W-1] ? (W+1)'(-$signed({num[W-1], num})) : {1'b0, num};
  assign trial = {rem, dividend[N-1]} - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {nmag[W-1:0], {gatk_pkg::FracBits{1'b0}}};
      rem      <= '0;
      q        <= '0;
      dmag     <= den[W-1] ? (W+1)'(-$signed({den[W-1], den})) : {1'b0, den};
      neg      <= num[W-1] ^ den[W-1];
      zero     <= (den == '0);
    end else if (busy) begin
      dividend <= {dividend[N-2:0], 1'b0};
      if (!trial[W+1]) begin
        rem <= trial[W:0];
        q   <= {q[N-2:0], 1'b1};
      end else begin
        rem <= {rem[W-1:0], dividend[N-1]};
        q   <= {q[N-2:0], 1'b0};
      end
    end
  end

  // a num magnitude of 2^(W-1) still fits in the low W bits of nmag
  logic [N:0] qfull;
  assign qfull = {1'b0, q};
  assign quot = zero ? '0 :
    gatk_pkg::sat_mag((2*W)'(qfull), neg);
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for the tilt Kalman filter: predictor, scoreboard, random traffic.
`default_nettype none
module testbench;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  class tilt_scoreboard;
    longint dt_reg, meas_noise, q_angle, q_bias;
    longint angle, bias, p00, p01, p10, p11;
    logic signed [31:0] exp_angle[$];
    logic signed [31:0] exp_bias[$];
    int errors;
    int checked;

    function new();
      dt_reg = 3277; meas_noise = 65536; q_angle = 66; q_bias = 197;
      angle = 0; bias = 0; p00 = 196608; p01 = 0; p10 = 0; p11 = 196608;
      errors = 0; checked = 0;
    endfunction

    function longint clip(longint v);
      if (v > QMax) return QMax;
      if (v < QMin) return QMin;
      return v;
    endfunction

    // Q16.16 product, truncated toward zero, saturated
    function longint qmul(longint a, longint b);
      logic signed [127:0] p;
      p = $signed(128'(a)) * $signed(128'(b));
      if (p < 0) p = -((-p) >>> 16);
      else p = p >>> 16;
      if (p > QMax) return QMax;
      if (p < QMin) return QMin;
      return longint'(p);
    endfunction

    function longint qdiv(longint n, longint d);
      logic signed [127:0] q;
      if (d == 0) return 0;
      q = ($signed(128'(n)) <<< 16) / $signed(128'(d));
      if (q > QMax) return QMax;
      if (q < QMin) return QMin;
      return longint'(q);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        gatk_pkg::RegDt:    dt_reg = v[16:0];
        gatk_pkg::RegMeas:  meas_noise = v[30:0];
        gatk_pkg::RegQAng:  q_angle = v[30:0];
        default:            q_bias = v[30:0];
      endcase
    endfunction

    function void note_sample(logic signed [31:0] rate, logic signed [31:0] meas);
      longint dt, inn, s, ap00, ap01, ap10, ap11, k0, k1, c0, c1, a00, a10;
      dt = clip(dt_reg);
      angle = clip(angle + qmul(dt, clip(longint'(rate) - bias)));
      inn = clip(longint'(meas) - angle);
      s = clip(p00 + clip(meas_noise));
      ap00 = clip(p00 - qmul(dt, p10));
      ap01 = clip(p01 - qmul(dt, p11));
      ap10 = p10;
      ap11 = p11;
      k0 = qdiv(ap00, s);
      k1 = qdiv(ap10, s);
      angle = clip(angle + qmul(k0, inn));
      bias = clip(bias + qmul(k1, inn));
      c0 = clip(p00 - qmul(dt, p01));
      c1 = p01;
      a00 = clip(ap00 - qmul(dt, ap01));
      a10 = clip(ap10 - qmul(dt, ap11));
      p00 = clip(clip(a00 - qmul(k0, c0)) + clip(q_angle));
      p01 = clip(ap01 - qmul(k0, c1));
      p10 = clip(a10 - qmul(k1, c0));
      p11 = clip(clip(ap11 - qmul(k1, c1)) + clip(q_bias));
      exp_angle.push_back(32'(angle));
      exp_bias.push_back(32'(bias));
    endfunction

    function void check_estimate(logic signed [31:0] ang, logic signed [31:0] bs);
      logic signed [31:0] ea, eb;
      if (exp_angle.size() == 0) begin
        $display("%0t: unexpected result angle=%0d bias=%0d", $time, ang, bs);
        errors++;
        return;
      end
      ea = exp_angle.pop_front();
      eb = exp_bias.pop_front();
      checked++;
      if (ang !== ea) begin
        $display("%0t: angle_estimate expected %0d got %0d", $time, ea, ang);
        errors++;
      end
      if (bs !== eb) begin
        $display("%0t: bias_estimate expected %0d got %0d", $time, eb, bs);
        errors++;
      end
    endfunction

    function int pending();
      return exp_angle.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = gatk_pkg::RegDt;
  logic [31:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] rate_sample = 0;
  logic signed [31:0] tilt_sample = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;

  tilt_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;
  int samples_sent = 0;

  always #6 clk = ~clk;

  gyro_accel_tilt_kalman dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .rate_sample(rate_sample), .tilt_sample(tilt_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .angle_estimate(angle_estimate), .bias_estimate(bias_estimate)
  );

  // result side: check transfers, randomize ready
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_estimate(angle_estimate, bias_estimate);
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("watchdog expired, %0d results outstanding", sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // in_valid stays up between back-to-back transfers; drain lowers it
  task automatic send_sample(logic signed [31:0] rate, logic signed [31:0] meas);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    rate_sample <= rate;
    tilt_sample <= meas;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(rate, meas);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 60 << 16)) - (30 << 16));
    endcase
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_sample(rand_field(), rand_field());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: defaults, field extremes, zero and negative innovation variance
    send_sample(0, 0);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(-1, 1);
    send_sample(5 << 16, -(3 << 16));
    drain();
    write_reg(gatk_pkg::RegDt, 0);
    write_reg(gatk_pkg::RegMeas, 0);
    write_reg(gatk_pkg::RegQAng, 0);
    write_reg(gatk_pkg::RegQBias, 0);
    send_sample(1 << 16, 2 << 16);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    write_reg(gatk_pkg::RegDt, 65536);
    write_reg(gatk_pkg::RegMeas, 32'h7FFF_FFFF);
    write_reg(gatk_pkg::RegQAng, 32'h7FFF_FFFF);
    write_reg(gatk_pkg::RegQBias, 32'h7FFF_FFFF);
    repeat (6) send_sample(rand_field(), rand_field());
    drain();
    write_reg(gatk_pkg::RegDt, 32'hFFFF_FFFF);
    write_reg(gatk_pkg::RegMeas, 32'hFFFF_FFFF);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555);
    drain();
    // random phases over several register settings
    write_reg(gatk_pkg::RegDt, 3277);
    write_reg(gatk_pkg::RegMeas, 65536);
    write_reg(gatk_pkg::RegQAng, 66);
    write_reg(gatk_pkg::RegQBias, 197);
    random_phase(300, 0, 0);
    write_reg(gatk_pkg::RegDt, $urandom_range(65536));
    write_reg(gatk_pkg::RegMeas, $urandom_range(1 << 20));
    write_reg(gatk_pkg::RegQAng, $urandom_range(1 << 16));
    write_reg(gatk_pkg::RegQBias, $urandom_range(1 << 16));
    random_phase(250, 76, 0);
    write_reg(gatk_pkg::RegMeas, $urandom());
    write_reg(gatk_pkg::RegQAng, $urandom());
    random_phase(250, 0, 76);
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (1500) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20, 0, 0);
    join
    write_reg(gatk_pkg::RegDt, 1);
    write_reg(gatk_pkg::RegQBias, 0);
    random_phase(300, 33, 33);
    $display("%0d samples checked, %0d sent, across reset, zero, maximum and random settings",
             sb.checked, samples_sent);
    $display("stall phases: none, sender idle, receiver stall, both, long hold-off");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
